>>> sv/szx_pkg.sv
`default_nettype none
package szx_pkg;

   // Event codes carried on the result channel.
   typedef enum logic [2:0] {
      EV_PAYLOAD = 3'd0,
      EV_NAME    = 3'd1,
      EV_MKDIR   = 3'd2,
      EV_BEGIN   = 3'd3,
      EV_END     = 3'd4,
      EV_ERROR   = 3'd5,
      EV_DONE    = 3'd6
   } event_type;

   // Error codes reported with an error event.
   typedef enum logic [2:0] {
      ERR_HEADER   = 3'd0,
      ERR_COMPRESS = 3'd1,
      ERR_PATH     = 3'd2,
      ERR_CANCEL   = 3'd3,
      ERR_PAYLOAD  = 3'd4,
      ERR_CHECKSUM = 3'd5
   } error_type;

   // Input kinds.
   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_END    = 2'd1,
      KIND_CANCEL = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   // Path component classification.
   typedef enum logic [1:0] {
      CK_EMPTY  = 2'd0,
      CK_DOT    = 2'd1,
      CK_DOTDOT = 2'd2,
      CK_OTHER  = 2'd3
   } comp_type;

   localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES      = 32'hFFFFFFFF;
   localparam logic [31:0] SIG_LOCAL     = 32'h04034B50;
   localparam logic [31:0] SIG_DESC      = 32'h08074B50;
   localparam int          MAX_RESULTS   = 4;
   localparam int          HEADER_BYTES  = 26;

   // One result item, without the last flag, which is derived on output.
   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  out_byte;
      logic [31:0] file_size;
      logic [2:0]  error_code;
   } item_type;

   // All results caused by one input transaction.
   typedef struct packed {
      logic [2:0]                     count;
      item_type [MAX_RESULTS-1:0]     item;
   } group_type;

   function automatic item_type make_item(input event_type ev, input logic [7:0] b,
                                          input logic [31:0] size, input error_type code);
      item_type r;
      r.event_res  = ev;
      r.out_byte   = b;
      r.file_size  = size;
      r.error_code = code;
      return r;
   endfunction

   // Reflected CRC-32 update over one byte.
   function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> sv/szx_if.sv
`default_nettype none
interface szx_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   modport source (output valid, kind, data_byte, input ready);
   modport sink (input valid, kind, data_byte, output ready);
endinterface

interface szx_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [7:0]  out_byte;
   logic [31:0] file_size;
   logic [2:0]  error_code;
   logic        last_of_run;
   modport source (output valid, event_res, out_byte, file_size, error_code, last_of_run,
                   input ready);
   modport sink (input valid, event_res, out_byte, file_size, error_code, last_of_run,
                 output ready);
endinterface
`default_nettype wire

>>> sv/szx_parse.sv
`default_nettype none
module szx_parse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_valid,
   input  wire logic [1:0]        kind,
   input  wire logic [7:0]        data_byte,
   output szx_pkg::group_type     group
);
   import szx_pkg::*;

   typedef enum logic [8:0] {
      PH_SIG     = 9'b000000001,
      PH_HDR     = 9'b000000010,
      PH_NAME    = 9'b000000100,
      PH_EXTRA   = 9'b000001000,
      PH_PAY     = 9'b000010000,
      PH_DFIRST  = 9'b000100000,
      PH_DSIGNED = 9'b001000000,
      PH_DPLAIN  = 9'b010000000,
      PH_DONE    = 9'b100000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] fc_ff, fc_in;
   logic [31:0] sig_ff, sig_in;
   logic        desc_ff, desc_in;
   logic [15:0] method_ff, method_in;
   logic [31:0] exp_crc_ff, exp_crc_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] usize_ff, usize_in;
   logic [15:0] nlen_ff, nlen_in;
   logic [15:0] xlen_ff, xlen_in;
   logic [31:0] crc_ff, crc_in;
   logic        unsafe_ff, unsafe_in;
   comp_type    comp_ff, comp_in;
   logic        slash_ff, slash_in;

   // Next state and the results of one transaction, worked in model order.
   always_comb begin
      logic [2:0]  n;
      logic        do_after, do_finish, do_endpay, do_check;
      logic [15:0] fc_inc;
      logic [7:0]  b;
      n         = 3'd0;
      do_after  = 1'b0;
      do_finish = 1'b0;
      do_endpay = 1'b0;
      do_check  = 1'b0;
      b         = data_byte;
      fc_inc    = fc_ff + 16'd1;
      group     = '0;
      phase_in   = phase_ff;
      fc_in      = fc_ff;
      sig_in     = sig_ff;
      desc_in    = desc_ff;
      method_in  = method_ff;
      exp_crc_in = exp_crc_ff;
      remain_in  = remain_ff;
      usize_in   = usize_ff;
      nlen_in    = nlen_ff;
      xlen_in    = xlen_ff;
      crc_in     = crc_ff;
      unsafe_in  = unsafe_ff;
      comp_in    = comp_ff;
      slash_in   = slash_ff;

      if (phase_ff != PH_DONE) begin
         unique case (kind_type'(kind))
            KIND_BYTE: begin
               unique case (phase_ff)
                  PH_SIG: begin
                     sig_in = {b, sig_ff[31:8]};
                     fc_in  = fc_inc;
                     if (fc_inc == 16'd4) begin
                        if (sig_in == SIG_LOCAL) begin
                           phase_in   = PH_HDR;
                           fc_in      = '0;
                           desc_in    = 1'b0;
                           method_in  = '0;
                           exp_crc_in = '0;
                           remain_in  = '0;
                           usize_in   = '0;
                           nlen_in    = '0;
                           xlen_in    = '0;
                           unsafe_in  = 1'b0;
                           comp_in    = CK_EMPTY;
                           slash_in   = 1'b0;
                        end else begin
                           group.item[n[1:0]] = make_item(EV_DONE, '0, '0, ERR_HEADER);
                           n        = n + 3'd1;
                           phase_in = PH_DONE;
                        end
                     end
                  end
                  PH_HDR: begin
                     // Little-endian header fields, one byte at a time.
                     priority case (fc_ff)
                        16'd2:  desc_in = b[3];
                        16'd4:  method_in[7:0]   = b;
                        16'd5:  method_in[15:8]  = b;
                        16'd10: exp_crc_in[7:0]   = b;
                        16'd11: exp_crc_in[15:8]  = b;
                        16'd12: exp_crc_in[23:16] = b;
                        16'd13: exp_crc_in[31:24] = b;
                        16'd14: remain_in[7:0]   = b;
                        16'd15: remain_in[15:8]  = b;
                        16'd16: remain_in[23:16] = b;
                        16'd17: remain_in[31:24] = b;
                        16'd18: usize_in[7:0]   = b;
                        16'd19: usize_in[15:8]  = b;
                        16'd20: usize_in[23:16] = b;
                        16'd21: usize_in[31:24] = b;
                        16'd22: nlen_in[7:0]  = b;
                        16'd23: nlen_in[15:8] = b;
                        16'd24: xlen_in[7:0]  = b;
                        16'd25: xlen_in[15:8] = b;
                        default: ;
                     endcase
                     fc_in = fc_inc;
                     if (fc_inc == 16'(HEADER_BYTES)) begin
                        fc_in = '0;
                        if (nlen_in != '0) phase_in = PH_NAME;
                        else               do_after = 1'b1;
                     end
                  end
                  PH_NAME: begin
                     group.item[n[1:0]] = make_item(EV_NAME, b, '0, ERR_HEADER);
                     n = n + 3'd1;
                     if (fc_ff == '0 && (b == 8'h2F || b == 8'h5C)) unsafe_in = 1'b1;
                     if (b == 8'h5C || b == 8'h3A) unsafe_in = 1'b1;
                     if (b == 8'h2F) begin
                        if (comp_ff == CK_DOTDOT) unsafe_in = 1'b1;
                        comp_in = CK_EMPTY;
                     end else if (b == 8'h2E) begin
                        comp_in = (comp_ff == CK_EMPTY) ? CK_DOT :
                                  (comp_ff == CK_DOT) ? CK_DOTDOT : CK_OTHER;
                     end else begin
                        comp_in = CK_OTHER;
                     end
                     slash_in = (b == 8'h2F);
                     fc_in    = fc_inc;
                     if (fc_inc >= nlen_ff) begin
                        fc_in    = '0;
                        do_after = 1'b1;
                     end
                  end
                  PH_EXTRA: begin
                     fc_in = fc_inc;
                     if (fc_inc >= xlen_ff) begin
                        fc_in     = '0;
                        do_finish = 1'b1;
                     end
                  end
                  PH_PAY: begin
                     group.item[n[1:0]] = make_item(EV_PAYLOAD, b, '0, ERR_HEADER);
                     n         = n + 3'd1;
                     crc_in    = crc_update(crc_ff, b);
                     remain_in = remain_ff - 32'd1;
                     if (remain_in == '0) do_endpay = 1'b1;
                  end
                  PH_DFIRST: begin
                     sig_in = {b, sig_ff[31:8]};
                     fc_in  = fc_inc;
                     if (fc_inc == 16'd4) begin
                        fc_in = '0;
                        if (sig_in == SIG_DESC) begin
                           exp_crc_in = '0;
                           phase_in   = PH_DSIGNED;
                        end else begin
                           exp_crc_in = sig_in;
                           phase_in   = PH_DPLAIN;
                        end
                     end
                  end
                  PH_DSIGNED: begin
                     priority case (fc_ff)
                        16'd0: exp_crc_in[7:0]   = b;
                        16'd1: exp_crc_in[15:8]  = b;
                        16'd2: exp_crc_in[23:16] = b;
                        16'd3: exp_crc_in[31:24] = b;
                        default: ;
                     endcase
                     fc_in = fc_inc;
                     if (fc_inc == 16'd12) do_check = 1'b1;
                  end
                  PH_DPLAIN: begin
                     fc_in = fc_inc;
                     if (fc_inc == 16'd8) do_check = 1'b1;
                  end
                  default: ;
               endcase
            end
            KIND_END: begin
               if (phase_ff == PH_SIG) begin
                  group.item[n[1:0]] = make_item(EV_DONE, '0, '0, ERR_HEADER);
                  n = n + 3'd1;
               end else if (phase_ff == PH_HDR || phase_ff == PH_NAME ||
                            phase_ff == PH_EXTRA) begin
                  group.item[n[1:0]] = make_item(EV_ERROR, '0, '0, ERR_HEADER);
                  n = n + 3'd1;
               end else begin
                  if (phase_ff == PH_PAY) begin
                     group.item[n[1:0]] = make_item(EV_END, '0, '0, ERR_HEADER);
                     n = n + 3'd1;
                  end
                  group.item[n[1:0]] = make_item(EV_ERROR, '0, '0, ERR_PAYLOAD);
                  n = n + 3'd1;
               end
               phase_in = PH_DONE;
            end
            KIND_CANCEL: begin
               if (phase_ff == PH_PAY) begin
                  group.item[n[1:0]] = make_item(EV_END, '0, '0, ERR_HEADER);
                  group.item[1]      = make_item(EV_ERROR, '0, '0, ERR_CANCEL);
                  n        = 3'd2;
                  phase_in = PH_DONE;
               end
            end
            KIND_UNUSED: ;
         endcase
      end

      // End of name: skip the extra field or close the header.
      if (do_after) begin
         if (xlen_in != '0) begin
            phase_in = PH_EXTRA;
            fc_in    = '0;
         end else begin
            do_finish = 1'b1;
         end
      end

      // Header verdict: method first, then path.
      if (do_finish) begin
         if (method_in != '0) begin
            group.item[n[1:0]] = make_item(EV_ERROR, '0, '0, ERR_COMPRESS);
            n        = n + 3'd1;
            phase_in = PH_DONE;
         end else if (unsafe_in || nlen_in == '0 || comp_in == CK_DOTDOT) begin
            group.item[n[1:0]] = make_item(EV_ERROR, '0, '0, ERR_PATH);
            n        = n + 3'd1;
            phase_in = PH_DONE;
         end else if (slash_in) begin
            group.item[n[1:0]] = make_item(EV_MKDIR, '0, '0, ERR_HEADER);
            n        = n + 3'd1;
            phase_in = PH_SIG;
            fc_in    = '0;
            sig_in   = '0;
         end else begin
            group.item[n[1:0]] = make_item(EV_BEGIN, '0, usize_in, ERR_HEADER);
            n      = n + 3'd1;
            crc_in = CRC_ONES;
            if (remain_in == '0) begin
               do_endpay = 1'b1;
            end else begin
               phase_in = PH_PAY;
               fc_in    = '0;
            end
         end
      end

      // Payload complete: read a descriptor or check the CRC now.
      if (do_endpay) begin
         group.item[n[1:0]] = make_item(EV_END, '0, '0, ERR_HEADER);
         n = n + 3'd1;
         if (desc_in) begin
            phase_in = PH_DFIRST;
            fc_in    = '0;
            sig_in   = '0;
         end else begin
            do_check = 1'b1;
         end
      end

      if (do_check) begin
         if ((crc_in ^ CRC_ONES) != exp_crc_in) begin
            group.item[n[1:0]] = make_item(EV_ERROR, '0, '0, ERR_CHECKSUM);
            n        = n + 3'd1;
            phase_in = PH_DONE;
         end else begin
            phase_in = PH_SIG;
            fc_in    = '0;
            sig_in   = '0;
         end
      end

      group.count = n;
   end

   // Parser state advances on each accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SIG;
         fc_ff      <= '0;
         sig_ff     <= '0;
         desc_ff    <= 1'b0;
         method_ff  <= '0;
         exp_crc_ff <= '0;
         remain_ff  <= '0;
         usize_ff   <= '0;
         nlen_ff    <= '0;
         xlen_ff    <= '0;
         crc_ff     <= CRC_ONES;
         unsafe_ff  <= 1'b0;
         comp_ff    <= CK_EMPTY;
         slash_ff   <= 1'b0;
      end else if (step_valid) begin
         phase_ff   <= phase_in;
         fc_ff      <= fc_in;
         sig_ff     <= sig_in;
         desc_ff    <= desc_in;
         method_ff  <= method_in;
         exp_crc_ff <= exp_crc_in;
         remain_ff  <= remain_in;
         usize_ff   <= usize_in;
         nlen_ff    <= nlen_in;
         xlen_ff    <= xlen_in;
         crc_ff     <= crc_in;
         unsafe_ff  <= unsafe_in;
         comp_ff    <= comp_in;
         slash_ff   <= slash_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/stored_zip_extract_crc_check.sv
// Results of a transaction are registered in the group buffer before output.
// Throughput: one input transaction per cycle while each causes at most one
// result and the result port is ready; requests stall while the two-group
// buffer is full, and a group of several results drains one at a time.
// Reset: synchronous, active high; clears parser state and empties the buffer.
`default_nettype none
module stored_zip_extract_crc_check (
   input  wire logic clock,
   input  wire logic reset,
   szx_req_if.sink   req_chan,
   szx_rsp_if.source rsp_chan
);
   import szx_pkg::*;

   group_type   group;
   group_type   grp_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic [1:0]  idx_ff;
   logic        accept, push, pop;
   group_type   head;
   item_type    cur;
   logic        head_last;

   assign req_chan.ready = (count_ff != 2'd2);
   assign accept = req_chan.valid && req_chan.ready;

   szx_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step_valid (accept),
      .kind       (req_chan.kind),
      .data_byte  (req_chan.data_byte),
      .group      (group)
   );

   // Output side of the group buffer.
   assign head      = grp_ff[rd_ptr_ff];
   assign cur       = head.item[idx_ff];
   assign head_last = ({1'b0, idx_ff} == head.count - 3'd1);
   assign push      = accept && (group.count != 3'd0);
   assign pop       = rsp_chan.valid && rsp_chan.ready && head_last;

   assign rsp_chan.valid       = (count_ff != 2'd0);
   assign rsp_chan.event_res   = cur.event_res;
   assign rsp_chan.out_byte    = cur.out_byte;
   assign rsp_chan.file_size   = cur.file_size;
   assign rsp_chan.error_code  = cur.error_code;
   assign rsp_chan.last_of_run = head_last;

   // Group storage.
   always_ff @(posedge clock) begin
      if (push) grp_ff[wr_ptr_ff] <= group;
   end

   // Buffer pointers and the index within the head group.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
         idx_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
            idx_ff    <= '0;
         end else if (rsp_chan.valid && rsp_chan.ready) begin
            idx_ff <= idx_ff + 2'd1;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // The buffer never holds more than two groups.
   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("group buffer overflow");

   // A stored group always holds at least one result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (head.count != 3'd0 && {1'b0, idx_ff} < head.count))
      else $error("result index outside head group");

   // A push into a full buffer must not happen.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !push)
      else $error("push while full");

endmodule
`default_nettype wire
